### design/cascaded_attitude_pd_controller_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cascaded attitude / rate PD controller
// Shared concurrent assertion forms, clocked on clk with synchronous rst.
// ----------------------------------------------------------------------------
`ifndef CASCADED_ATTITUDE_PD_CONTROLLER_MACROS_SVH
`define CASCADED_ATTITUDE_PD_CONTROLLER_MACROS_SVH

// Same-cycle implication, off during reset
`define CAP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset
`define CAP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Condition that must hold in the cycle after reset
`define CAP_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

### design/cap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cap_pkg
// Types, constants and helper functions shared by the attitude PD controller.
// ----------------------------------------------------------------------------
package cap_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 24;
  localparam int ISQRT_STEPS       = 32;
  localparam int OW                = 32;  // operand width out of the quaternion math
  localparam int CW                = 40;  // CORDIC x/y width
  localparam int ZW                = 24;  // CORDIC angle width, Q16
  localparam int AW                = 16;  // angle width, Q6.10
  localparam int KW                = 38;  // wide clamp width

  localparam logic signed [ZW-1:0] PI_Q16     = 24'sd205887;
  localparam logic signed [16:0]   PI_Q10     = 17'sd3217;
  localparam logic signed [16:0]   TWO_PI_Q10 = 17'sd6434;

  localparam logic [47:0] GAIN_RESET         = 48'd0;
  localparam logic [14:0] TILT_LIMIT_RESET   = 15'd804;
  localparam logic [47:0] RATE_LIMIT_RESET   = 48'd46055637068259;
  localparam logic [47:0] MOMENT_LIMIT_RESET = 48'd433851991134;

  typedef enum logic [2:0] {
    REG_ANGLE_GAIN_P  = 3'd0,
    REG_ANGLE_GAIN_D  = 3'd1,
    REG_RATE_GAIN_P   = 3'd2,
    REG_RATE_GAIN_D   = 3'd3,
    REG_TILT_LIMIT    = 3'd4,
    REG_RATE_LIMIT    = 3'd5,
    REG_MOMENT_LIMIT  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [47:0] angle_gain_p;
    logic [47:0] angle_gain_d;
    logic [47:0] rate_gain_p;
    logic [47:0] rate_gain_d;
    logic [14:0] tilt_limit;
    logic [47:0] rate_limit;
    logic [47:0] moment_limit;
  } cfg_t;

  // Fields that ride along untouched until the PD stages
  typedef struct packed {
    logic signed [15:0] force_x;
    logic signed [15:0] force_y;
    logic [47:0]        body_rate;
    logic [47:0]        target_rate;
    logic [47:0]        body_accel;
  } side_t;

  // atan2 operands from the quaternion
  typedef struct packed {
    logic signed [OW-1:0] roll_y;
    logic signed [OW-1:0] roll_x;
    logic signed [OW-1:0] pitch_y;
    logic signed [OW-1:0] yaw_y;
    logic signed [OW-1:0] yaw_x;
  } ang_op_t;

  typedef struct packed {
    ang_op_t ops;
    side_t   side;
  } iq_side_t;

  // arctan(2^-i) in Q16
  function automatic logic signed [ZW-1:0] atan_q16(input int i);
    case (i)
      0:       atan_q16 = ZW'(51472);
      1:       atan_q16 = ZW'(30386);
      2:       atan_q16 = ZW'(16055);
      3:       atan_q16 = ZW'(8150);
      4:       atan_q16 = ZW'(4091);
      5:       atan_q16 = ZW'(2047);
      6:       atan_q16 = ZW'(1024);
      7:       atan_q16 = ZW'(512);
      8:       atan_q16 = ZW'(256);
      9:       atan_q16 = ZW'(128);
      10:      atan_q16 = ZW'(64);
      11:      atan_q16 = ZW'(32);
      12:      atan_q16 = ZW'(16);
      13:      atan_q16 = ZW'(8);
      14:      atan_q16 = ZW'(4);
      15:      atan_q16 = ZW'(2);
      16:      atan_q16 = ZW'(1);
      default: atan_q16 = '0;
    endcase
  endfunction

  // Clamp to +-lim, lim an unsigned 16-bit magnitude
  function automatic logic signed [KW-1:0] clamp_s(input logic signed [KW-1:0] v,
                                                   input logic [15:0] lim);
    logic signed [KW-1:0] l;
    l = $signed({{(KW-16){1'b0}}, lim});
    if (v > l) clamp_s = l;
    else if (v < -l) clamp_s = -l;
    else clamp_s = v;
  endfunction

endpackage

### design/cap_quat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cap_quat
// Quaternion products, atan2 operands and the squared roll hypotenuse.
// Three register stages.
// ----------------------------------------------------------------------------
module cap_quat (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic signed [14:0]    quat_w,
  input  logic signed [14:0]    quat_x,
  input  logic signed [14:0]    quat_y,
  input  logic signed [14:0]    quat_z,
  input  cap_pkg::side_t        side_in,
  output logic                  out_valid,
  output cap_pkg::ang_op_t      ops,
  output logic [63:0]           sq,
  output cap_pkg::side_t        side_out
);

  logic signed [29:0] p_ww, p_xx, p_yy, p_zz, p_yz, p_wx, p_wy, p_xz, p_xy, p_wz;
  logic               v1, v2;
  cap_pkg::side_t     side1, side2;
  cap_pkg::ang_op_t   ops2;
  logic signed [63:0] ry_sq, rx_sq;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // Stage 1: pairwise products
  always_ff @(posedge clk) begin
    if (en) begin
      p_ww  <= quat_w * quat_w;
      p_xx  <= quat_x * quat_x;
      p_yy  <= quat_y * quat_y;
      p_zz  <= quat_z * quat_z;
      p_yz  <= quat_y * quat_z;
      p_wx  <= quat_w * quat_x;
      p_wy  <= quat_w * quat_y;
      p_xz  <= quat_x * quat_z;
      p_xy  <= quat_x * quat_y;
      p_wz  <= quat_w * quat_z;
      side1 <= side_in;
    end
  end

  // Stage 2: atan2 operands
  always_ff @(posedge clk) begin
    if (en) begin
      ops2.roll_y  <= (32'(p_yz) + 32'(p_wx)) <<< 1;
      ops2.roll_x  <= 32'(p_ww) - 32'(p_xx) - 32'(p_yy) + 32'(p_zz);
      ops2.pitch_y <= (32'(p_wy) - 32'(p_xz)) <<< 1;
      ops2.yaw_y   <= (32'(p_xy) + 32'(p_wz)) <<< 1;
      ops2.yaw_x   <= 32'(p_ww) + 32'(p_xx) - 32'(p_yy) - 32'(p_zz);
      side2        <= side1;
    end
  end

  // Stage 3: squared magnitude of the roll vector
  assign ry_sq = ops2.roll_y * ops2.roll_y;
  assign rx_sq = ops2.roll_x * ops2.roll_x;

  always_ff @(posedge clk) begin
    if (en) begin
      sq       <= $unsigned(ry_sq + rx_sq);
      ops      <= ops2;
      side_out <= side2;
    end
  end

endmodule

### design/cap_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cap_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module cap_isqrt (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [63:0]          sq,
  input  cap_pkg::iq_side_t    side_in,
  output logic                 out_valid,
  output logic [31:0]          hyp,
  output cap_pkg::iq_side_t    side_out
);

  localparam int N = cap_pkg::ISQRT_STEPS;

  logic [63:0]       v_r   [N];
  logic [63:0]       r_r   [N];
  logic [N-1:0]      vld;
  cap_pkg::iq_side_t sd_r  [N];

  for (genvar g = 0; g < N; g++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
    logic [63:0]       v_in, r_in, trial;
    logic              vl_in;
    cap_pkg::iq_side_t sd_in;

    if (g == 0) begin : g_first
      assign v_in  = sq;
      assign r_in  = '0;
      assign vl_in = in_valid;
      assign sd_in = side_in;
    end else begin : g_next
      assign v_in  = v_r[g-1];
      assign r_in  = r_r[g-1];
      assign vl_in = vld[g-1];
      assign sd_in = sd_r[g-1];
    end

    assign trial = r_in + BIT;

    // Hold the valid bit with the stage
    always_ff @(posedge clk) begin
      if (rst) vld[g] <= 1'b0;
      else if (en) vld[g] <= vl_in;
    end

    // Compare, subtract and shift in one root bit
    always_ff @(posedge clk) begin
      if (en) begin
        if (v_in >= trial) begin
          v_r[g] <= v_in - trial;
          r_r[g] <= (r_in >> 1) + BIT;
        end else begin
          v_r[g] <= v_in;
          r_r[g] <= r_in >> 1;
        end
        sd_r[g] <= sd_in;
      end
    end
  end

  assign out_valid = vld[N-1];
  assign hyp       = r_r[N-1][31:0];
  assign side_out  = sd_r[N-1];

endmodule

### design/cap_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cap_cordic
// Three-lane pipelined vectoring CORDIC giving atan2 in Q6.10.
// Lane 0 roll, lane 1 pitch, lane 2 yaw.
// ----------------------------------------------------------------------------
module cap_cordic #(
  parameter int STAGES = cap_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [cap_pkg::OW-1:0] y_in [3],
  input  logic signed [cap_pkg::OW-1:0] x_in [3],
  input  cap_pkg::side_t                side_in,
  output logic                          out_valid,
  output logic signed [cap_pkg::AW-1:0] ang [3],
  output cap_pkg::side_t                side_out
);

  localparam int CW = cap_pkg::CW;
  localparam int ZW = cap_pkg::ZW;

  logic signed [CW-1:0] xr [STAGES+1][3];
  logic signed [CW-1:0] yr [STAGES+1][3];
  logic signed [ZW-1:0] zr [STAGES+1][3];
  logic [2:0]           zf [STAGES+1];
  logic [STAGES:0]      vld;
  cap_pkg::side_t       sd [STAGES+1];
  logic signed [CW-1:0] xe [3];
  logic signed [CW-1:0] ye [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      xe[k] = CW'(x_in[k]);
      ye[k] = CW'(y_in[k]);
    end
  end

  // Pre-rotate into the right half plane, flag the zero vector
  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        zf[0][k] <= (xe[k] == '0) && (ye[k] == '0);
        if (xe[k] < 0) begin
          xr[0][k] <= -xe[k];
          yr[0][k] <= -ye[k];
          zr[0][k] <= (ye[k] >= 0) ? cap_pkg::PI_Q16 : -cap_pkg::PI_Q16;
        end else begin
          xr[0][k] <= xe[k];
          yr[0][k] <= ye[k];
          zr[0][k] <= '0;
        end
      end
      sd[0] <= side_in;
    end
  end

  // Micro-rotations, one per stage
  for (genvar g = 0; g < STAGES; g++) begin : g_iter
    localparam logic signed [ZW-1:0] ATAN = cap_pkg::atan_q16(g);

    always_ff @(posedge clk) begin
      if (rst) vld[g+1] <= 1'b0;
      else if (en) vld[g+1] <= vld[g];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          if (yr[g][k] >= 0) begin
            xr[g+1][k] <= xr[g][k] + (yr[g][k] >>> g);
            yr[g+1][k] <= yr[g][k] - (xr[g][k] >>> g);
            zr[g+1][k] <= zr[g][k] + ATAN;
          end else begin
            xr[g+1][k] <= xr[g][k] - (yr[g][k] >>> g);
            yr[g+1][k] <= yr[g][k] + (xr[g][k] >>> g);
            zr[g+1][k] <= zr[g][k] - ATAN;
          end
        end
        zf[g+1] <= zf[g];
        sd[g+1] <= sd[g];
      end
    end
  end

  // Round Q16 to Q6.10
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vld[STAGES];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (zf[STAGES][k]) ang[k] <= '0;
        else ang[k] <= cap_pkg::AW'((zr[STAGES][k] + ZW'(32)) >>> 6);
      end
      side_out <= sd[STAGES];
    end
  end

endmodule

### design/cap_pd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cap_pd
// Attitude PD, rate clamp, rate PD and moment saturation in six stages.
// ----------------------------------------------------------------------------
module cap_pd (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [cap_pkg::AW-1:0] ang [3],
  input  cap_pkg::side_t                side_in,
  input  cap_pkg::cfg_t                 cfg,
  output logic                          out_valid,
  output logic signed [15:0]            moment [3]
);

  localparam int KW = cap_pkg::KW;

  logic [5:0]          vld;
  logic signed [16:0]  yaw_w;
  logic signed [16:0]  ang_w [3];
  logic signed [16:0]  cmd   [3];
  logic signed [15:0]  wr_in [3];
  logic signed [15:0]  wt_in [3];
  logic signed [15:0]  al_in [3];

  logic signed [17:0]  e_a [3], e_r [3];
  logic signed [15:0]  wr1 [3], al1 [3];
  logic signed [33:0]  pa  [3], pd  [3];
  logic signed [15:0]  wr2 [3], al2 [3];
  logic signed [17:0]  rc  [3];
  logic signed [15:0]  wr3 [3], al3 [3];
  logic signed [18:0]  e_m [3];
  logic signed [15:0]  al4 [3];
  logic signed [34:0]  mp  [3];
  logic signed [31:0]  md  [3];

  logic signed [KW-1:0] rsum [3], rrnd [3], rclp [3];
  logic signed [KW-1:0] msum [3], mrnd [3], mclp [3];

  // Valid bits through the six stages
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[4:0], in_valid};
  end
  assign out_valid = vld[5];

  // Wrap yaw, form commands and unpack lanes
  always_comb begin
    yaw_w = 17'(ang[2]);
    if (yaw_w > cap_pkg::PI_Q10) yaw_w = yaw_w - cap_pkg::TWO_PI_Q10;
    if (yaw_w <= -cap_pkg::PI_Q10) yaw_w = yaw_w + cap_pkg::TWO_PI_Q10;
    ang_w[0] = 17'(ang[0]);
    ang_w[1] = 17'(ang[1]);
    ang_w[2] = yaw_w;
    cmd[0] = 17'(cap_pkg::clamp_s(-KW'(side_in.force_y), {1'b0, cfg.tilt_limit}));
    cmd[1] = 17'(cap_pkg::clamp_s(KW'(side_in.force_x), {1'b0, cfg.tilt_limit}));
    cmd[2] = '0;
    for (int k = 0; k < 3; k++) begin
      wr_in[k] = $signed(side_in.body_rate[16*k +: 16]);
      wt_in[k] = $signed(side_in.target_rate[16*k +: 16]);
      al_in[k] = $signed(side_in.body_accel[16*k +: 16]);
    end
  end

  // Stage 1: attitude and rate errors
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e_a[k] <= 18'(cmd[k]) - 18'(ang_w[k]);
        e_r[k] <= 18'(wt_in[k]) - 18'(wr_in[k]);
        wr1[k] <= wr_in[k];
        al1[k] <= al_in[k];
      end
    end
  end

  // Stage 2: attitude gain products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pa[k]  <= $signed(cfg.angle_gain_p[16*k +: 16]) * e_a[k];
        pd[k]  <= $signed(cfg.angle_gain_d[16*k +: 16]) * e_r[k];
        wr2[k] <= wr1[k];
        al2[k] <= al1[k];
      end
    end
  end

  // Stage 3: sum, round and clamp the rate command
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rsum[k] = KW'(pa[k]) + KW'(pd[k]);
      rrnd[k] = (rsum[k] + KW'(128)) >>> 8;
      rclp[k] = cap_pkg::clamp_s(rrnd[k], cfg.rate_limit[16*k +: 16]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        rc[k]  <= 18'(rclp[k]);
        wr3[k] <= wr2[k];
        al3[k] <= al2[k];
      end
    end
  end

  // Stage 4: rate error
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e_m[k] <= 19'(rc[k]) - 19'(wr3[k]);
        al4[k] <= al3[k];
      end
    end
  end

  // Stage 5: rate gain products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mp[k] <= $signed(cfg.rate_gain_p[16*k +: 16]) * e_m[k];
        md[k] <= $signed(cfg.rate_gain_d[16*k +: 16]) * al4[k];
      end
    end
  end

  // Stage 6: round, clamp and saturate the moment
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      msum[k] = KW'(mp[k]) - KW'(md[k]);
      mrnd[k] = (msum[k] + KW'(128)) >>> 8;
      mclp[k] = cap_pkg::clamp_s(mrnd[k], cfg.moment_limit[16*k +: 16]);
      if (mclp[k] > KW'(32767)) mclp[k] = KW'(32767);
      if (mclp[k] < -KW'(32768)) mclp[k] = -KW'(32768);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) moment[k] <= 16'(mclp[k]);
    end
  end

endmodule

### design/cascaded_attitude_pd_controller.sv
// Throughput: one transaction per cycle while no result is held; every stage is
// registered and the square root and CORDIC run one step per pipeline stage.
// Backpressure freezes the whole pipeline; nothing is dropped or repeated.
// Reset: synchronous, clears all valid bits and loads register defaults.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_attitude_pd_controller
// Quaternion to Euler angles, attitude PD, rate PD and moment saturation.
// ----------------------------------------------------------------------------
module cascaded_attitude_pd_controller #(
  parameter int CORDIC_STAGES = cap_pkg::CORDIC_STAGES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // quat_w[14:0] quat_x[29:15] quat_y[44:30] quat_z[59:45] body_rate[107:60]
  // target_rate[155:108] body_accel[203:156] force_x[219:204] force_y[235:220]
  input  logic [239:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // moment_roll[15:0] moment_pitch[31:16] moment_yaw[47:32]
  output logic [47:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [47:0]  cfg_data
);

  localparam int NSTG = (CORDIC_STAGES > cap_pkg::ATAN_ENTRIES) ?
                        cap_pkg::ATAN_ENTRIES : CORDIC_STAGES;

  cap_pkg::cfg_t     cfg;
  logic              en;
  cap_pkg::side_t    side_in, q_side, c_side;
  cap_pkg::ang_op_t  q_ops;
  cap_pkg::iq_side_t iq_in, iq_out;
  logic [63:0]       q_sq;
  logic [31:0]       hyp;
  logic              q_valid, iq_valid, c_valid;
  logic signed [cap_pkg::OW-1:0] cy [3], cx [3];
  logic signed [cap_pkg::AW-1:0] ang [3];
  logic signed [15:0] moment [3];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_gain_p <= cap_pkg::GAIN_RESET;
      cfg.angle_gain_d <= cap_pkg::GAIN_RESET;
      cfg.rate_gain_p  <= cap_pkg::GAIN_RESET;
      cfg.rate_gain_d  <= cap_pkg::GAIN_RESET;
      cfg.tilt_limit   <= cap_pkg::TILT_LIMIT_RESET;
      cfg.rate_limit   <= cap_pkg::RATE_LIMIT_RESET;
      cfg.moment_limit <= cap_pkg::MOMENT_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cap_pkg::reg_idx_t'(cfg_index))
        cap_pkg::REG_ANGLE_GAIN_P: cfg.angle_gain_p <= cfg_data;
        cap_pkg::REG_ANGLE_GAIN_D: cfg.angle_gain_d <= cfg_data;
        cap_pkg::REG_RATE_GAIN_P:  cfg.rate_gain_p  <= cfg_data;
        cap_pkg::REG_RATE_GAIN_D:  cfg.rate_gain_d  <= cfg_data;
        cap_pkg::REG_TILT_LIMIT:   cfg.tilt_limit   <= cfg_data[14:0];
        cap_pkg::REG_RATE_LIMIT:   cfg.rate_limit   <= cfg_data;
        cap_pkg::REG_MOMENT_LIMIT: cfg.moment_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the pipeline unless a result is held
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Unpack the sideband
  assign side_in.force_x     = $signed(s_tdata[219:204]);
  assign side_in.force_y     = $signed(s_tdata[235:220]);
  assign side_in.body_rate   = s_tdata[107:60];
  assign side_in.target_rate = s_tdata[155:108];
  assign side_in.body_accel  = s_tdata[203:156];

  cap_quat u_quat (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .quat_w   ($signed(s_tdata[14:0])),
    .quat_x   ($signed(s_tdata[29:15])),
    .quat_y   ($signed(s_tdata[44:30])),
    .quat_z   ($signed(s_tdata[59:45])),
    .side_in  (side_in),
    .out_valid(q_valid),
    .ops      (q_ops),
    .sq       (q_sq),
    .side_out (q_side)
  );

  assign iq_in.ops  = q_ops;
  assign iq_in.side = q_side;

  cap_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (q_valid),
    .sq       (q_sq),
    .side_in  (iq_in),
    .out_valid(iq_valid),
    .hyp      (hyp),
    .side_out (iq_out)
  );

  // Roll, pitch and yaw operand pairs
  always_comb begin
    cy[0] = iq_out.ops.roll_y;
    cx[0] = iq_out.ops.roll_x;
    cy[1] = iq_out.ops.pitch_y;
    cx[1] = $signed(hyp);
    cy[2] = iq_out.ops.yaw_y;
    cx[2] = iq_out.ops.yaw_x;
  end

  cap_cordic #(
    .STAGES(NSTG)
  ) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (iq_valid),
    .y_in     (cy),
    .x_in     (cx),
    .side_in  (iq_out.side),
    .out_valid(c_valid),
    .ang      (ang),
    .side_out (c_side)
  );

  cap_pd u_pd (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (c_valid),
    .ang      (ang),
    .side_in  (c_side),
    .cfg      (cfg),
    .out_valid(m_tvalid),
    .moment   (moment)
  );

  assign m_tdata = {moment[2], moment[1], moment[0]};

endmodule

### design/cap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cap_checker
// Port-level checks of the controller's handshake behavior.
// ----------------------------------------------------------------------------
`include "cascaded_attitude_pd_controller_macros.svh"

module cap_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  `CAP_ASSERT_RST(a_rst_clears_out, !m_tvalid, "result valid right after reset")
  `CAP_ASSERT_NXT(a_hold_out, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "held result changed")
  `CAP_ASSERT_IMP(a_stall_cause, !s_tready, m_tvalid && !m_tready, "input stalled without backpressure")
  `CAP_ASSERT_IMP(a_accept_idle, s_tvalid && !m_tvalid, s_tready, "input refused with empty output")

endmodule

bind cascaded_attitude_pd_controller cap_checker u_cap_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
